### rtl/core/rect_region_hit_table_assert.svh
// Assertion macros for the click region table.
`ifndef RECT_REGION_HIT_TABLE_ASSERT_SVH
`define RECT_REGION_HIT_TABLE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define RRHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define RRHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/rrht_pkg.sv
// Shared types, codes and sizes for the click region table.
`timescale 1ns / 1ps
package rrht_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int KEY_CODES_DEF   = 256;
    localparam int CFG_W           = 7;

    localparam logic [3:0] OP_CREATE  = 4'd0;
    localparam logic [3:0] OP_ADD_KEY = 4'd1;
    localparam logic [3:0] OP_DESTROY = 4'd2;
    localparam logic [3:0] OP_SET_TYP = 4'd3;
    localparam logic [3:0] OP_SET_POS = 4'd4;
    localparam logic [3:0] OP_SET_SZ  = 4'd5;
    localparam logic [3:0] OP_SET_EXT = 4'd6;
    localparam logic [3:0] OP_SET_PRV = 4'd7;
    localparam logic [3:0] OP_SET_OWN = 4'd8;
    localparam logic [3:0] OP_READ    = 4'd9;
    localparam logic [3:0] OP_DETECT  = 4'd10;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_REJECT  = 3'd3;
    localparam logic [2:0] ST_NO_HIT  = 3'd4;
    localparam logic [2:0] ST_HIT     = 3'd5;

    typedef struct packed {
        logic [3:0]         opcode;
        logic [5:0]         tile_id;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [14:0]        width;
        logic [14:0]        height;
        logic [1:0]         tile_type;
        logic signed [31:0] extra_value;
        logic               private_flag;
        logic [7:0]         owner;
        logic [7:0]         key_code;
    } t_cmd;

    typedef struct packed {
        logic [2:0]         status;
        logic [5:0]         tile_id;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [14:0]        width;
        logic [14:0]        height;
        logic [1:0]         tile_type;
        logic signed [31:0] extra_value;
        logic               private_flag;
        logic [7:0]         owner;
        logic               broadcast;
        logic               last;
    } t_res;

endpackage

### rtl/core/rrht_cell.sv
// One table entry of the scan chain: storage, hit test and update.
`timescale 1ns / 1ps
module rrht_cell #(
    parameter int MAX_ENTRIES = 64,
    parameter int KEY_CODES   = 256,
    parameter int IDX         = 0,
    parameter int LIM_W       = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_tok,
    input  logic              i_done,
    input  rrht_pkg::t_cmd    i_cmd,
    input  logic [LIM_W-1:0]  i_limit,
    input  logic              i_clr,
    input  logic [LIM_W-1:0]  i_clr_from,
    output logic              o_tok,
    output logic              o_done,
    output logic              o_res_v,
    output rrht_pkg::t_res    o_res
);
    import rrht_pkg::*;

    localparam int KIDX_W = (KEY_CODES > 1) ? $clog2(KEY_CODES) : 1;
    localparam logic [LIM_W-1:0] MY_IDX = LIM_W'(IDX);

    logic                 r_tok, r_done, r_exists;
    logic signed [15:0]   r_cx, r_cy;
    logic [14:0]          r_wx, r_wy;
    logic [1:0]           r_shape;
    logic signed [31:0]   r_word;
    logic                 r_priv;
    logic [7:0]           r_owner;
    logic [KEY_CODES-1:0] r_mask;

    logic              usable, is_me, key_ok, key_hit, in_x, in_y, valid_id;
    logic              do_create, do_write;
    logic signed [16:0] x_hi, y_hi;
    logic [KIDX_W-1:0] kidx;

    always_comb begin
        usable   = MY_IDX < i_limit;
        is_me    = i_cmd.tile_id == 6'(IDX);
        kidx     = i_cmd.key_code[KIDX_W-1:0];
        key_ok   = {1'b0, i_cmd.key_code} < 9'(KEY_CODES);
        key_hit  = key_ok && r_mask[kidx];
        x_hi     = 17'(r_cx) + $signed({2'b00, r_wx});
        y_hi     = 17'(r_cy) + $signed({2'b00, r_wy});
        in_x     = (i_cmd.pos_x >= r_cx) && (17'(i_cmd.pos_x) <= x_hi);
        in_y     = (i_cmd.pos_y >= r_cy) && (17'(i_cmd.pos_y) <= y_hi);
        valid_id = r_exists && usable;
        do_create = 1'b0;
        do_write  = 1'b0;
        o_res_v   = 1'b0;
        o_res     = '0;
        o_res.tile_id = 6'(IDX);
        case (i_cmd.opcode)
            OP_CREATE: begin
                do_create = r_tok && !r_done && !r_exists && usable;
                o_res_v   = do_create;
            end
            OP_DETECT: begin
                if (r_tok && r_exists && usable && key_hit && r_shape == 2'd0 && in_x && in_y)
                begin
                    o_res_v        = 1'b1;
                    o_res.status   = ST_HIT;
                    o_res.pos_x    = i_cmd.pos_x;
                    o_res.pos_y    = i_cmd.pos_y;
                    o_res.owner    = r_owner;
                    o_res.broadcast = !(r_owner != 8'd0 && r_priv);
                end
            end
            default: begin
                o_res_v  = r_tok && is_me;
                do_write = r_tok && is_me && valid_id;
                if (!valid_id) begin
                    o_res.status = ST_INVALID;
                end else if (i_cmd.opcode == OP_SET_TYP && i_cmd.tile_type > 2'd1) begin
                    o_res.status = ST_REJECT;
                end else if (i_cmd.opcode == OP_READ) begin
                    o_res.pos_x        = r_cx;
                    o_res.pos_y        = r_cy;
                    o_res.width        = r_wx;
                    o_res.height       = r_wy;
                    o_res.tile_type    = r_shape;
                    o_res.extra_value  = r_word;
                    o_res.private_flag = r_priv;
                    o_res.owner        = r_owner;
                end
            end
        endcase
        o_tok  = r_tok;
        o_done = r_done || o_res_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= 1'b0;
            r_done   <= 1'b0;
            r_exists <= 1'b0;
        end else begin
            if (i_en) begin
                r_tok  <= i_tok;
                r_done <= i_done;
            end
            if (i_clr && MY_IDX >= i_clr_from) begin
                r_exists <= 1'b0;
            end
            if (i_en && do_create) begin
                r_exists <= 1'b1;
                r_cx     <= i_cmd.pos_x;
                r_cy     <= i_cmd.pos_y;
                r_wx     <= i_cmd.width;
                r_wy     <= i_cmd.height;
                r_shape  <= i_cmd.tile_type;
                r_word   <= i_cmd.extra_value;
                r_priv   <= i_cmd.private_flag;
                r_owner  <= i_cmd.owner;
                r_mask   <= '0;
                if (key_ok) begin
                    r_mask[kidx] <= 1'b1;
                end
            end
            if (i_en && do_write) begin
                case (i_cmd.opcode)
                    OP_ADD_KEY: if (key_ok) r_mask[kidx] <= 1'b1;
                    OP_DESTROY: r_exists <= 1'b0;
                    OP_SET_TYP: if (i_cmd.tile_type <= 2'd1) r_shape <= i_cmd.tile_type;
                    OP_SET_POS: begin
                        r_cx <= i_cmd.pos_x;
                        r_cy <= i_cmd.pos_y;
                    end
                    OP_SET_SZ: begin
                        r_wx <= i_cmd.width;
                        r_wy <= i_cmd.height;
                    end
                    OP_SET_EXT: r_word  <= i_cmd.extra_value;
                    OP_SET_PRV: r_priv  <= i_cmd.private_flag;
                    OP_SET_OWN: r_owner <= i_cmd.owner;
                    default: ;
                endcase
            end
        end
    end

endmodule

### rtl/core/rect_region_hit_table.sv
// An accepted request walks the token through every cell of the chain to its final result.
// A new request is refused (o_in_stall) until the walk of the last one has finished.
// Output backpressure freezes the walk when a new result has nowhere to go; unknown opcodes are taken with no result.
// Reset: synchronous active low; all entries empty, limit MAX_ENTRIES, no clearing pass.
// Top level of the click region table.
`timescale 1ns / 1ps
module rect_region_hit_table #(
    parameter int MAX_ENTRIES = rrht_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_CODES   = rrht_pkg::KEY_CODES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rrht_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [3:0]                    i_opcode,
    input  logic [5:0]                    i_tile_id,
    input  logic signed [15:0]            i_pos_x,
    input  logic signed [15:0]            i_pos_y,
    input  logic [14:0]                   i_width,
    input  logic [14:0]                   i_height,
    input  logic [1:0]                    i_tile_type,
    input  logic signed [31:0]            i_extra_value,
    input  logic                          i_private_flag,
    input  logic [7:0]                    i_owner,
    input  logic [7:0]                    i_key_code,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_status,
    output logic [5:0]                    o_tile_id_res,
    output logic signed [15:0]            o_pos_x_res,
    output logic signed [15:0]            o_pos_y_res,
    output logic [14:0]                   o_width_res,
    output logic [14:0]                   o_height_res,
    output logic [1:0]                    o_tile_type_res,
    output logic signed [31:0]            o_extra_value_res,
    output logic                          o_private_flag_res,
    output logic [7:0]                    o_owner_res,
    output logic                          o_broadcast,
    output logic                          o_last
);
    import rrht_pkg::*;
    `include "rect_region_hit_table_assert.svh"

    localparam int LIM_W = $clog2(MAX_ENTRIES + 1);

    // request held for the whole walk, broadcast to every cell
    t_cmd r_cmd;
    logic r_busy, r_end, r_end_done;
    logic [LIM_W-1:0] r_limit;
    // pending result: held back until we know whether it is the last one
    t_res r_pend;
    logic r_pend_v;
    t_res r_out;
    logic r_out_v;

    logic accept, start, chain_en, adv, slot_free, res_any, finish;
    logic cfg_hit, clr;
    logic [LIM_W-1:0] cfg_sat, clr_from;
    logic [MAX_ENTRIES:0] tok, done;
    logic [MAX_ENTRIES-1:0] cell_res_v;
    t_res cell_res [MAX_ENTRIES];
    t_res res_or, end_res, fin_res;
    t_cmd in_cmd;

    always_comb begin
        in_cmd = '{opcode: i_opcode, tile_id: i_tile_id, pos_x: i_pos_x, pos_y: i_pos_y,
                   width: i_width, height: i_height, tile_type: i_tile_type,
                   extra_value: i_extra_value, private_flag: i_private_flag,
                   owner: i_owner, key_code: i_key_code};
        accept    = i_in_valid && !r_busy;
        start     = accept && (i_opcode <= OP_DETECT);
        slot_free = !r_out_v || !i_out_stall;
        res_any   = |cell_res_v;
        // advance the walk unless a new result has nowhere to go
        adv       = r_busy && !r_end && (!(res_any && r_pend_v) || slot_free);
        chain_en  = start || adv;
        finish    = r_end && slot_free;
        tok[0]    = start;
        done[0]   = 1'b0;
        // only the cell holding the token drives its result
        res_or = '0;
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            res_or = res_or | (cell_res_v[k] ? cell_res[k] : '0);
        end
        // the held result becomes the final one
        fin_res      = r_pend;
        fin_res.last = 1'b1;
        end_res = '0;
        end_res.last = 1'b1;
        case (r_cmd.opcode)
            OP_CREATE: end_res.status = ST_FULL;
            OP_DETECT: end_res.status = ST_NO_HIT;
            default: begin
                end_res.status  = ST_INVALID;
                end_res.tile_id = r_cmd.tile_id;
            end
        endcase
        // limit write: drop zero, saturate, clear from the smaller limit up
        cfg_hit = i_cfg_we && (i_cfg_data != '0);
        cfg_sat = (i_cfg_data > CFG_W'(MAX_ENTRIES)) ? LIM_W'(MAX_ENTRIES)
                                                     : LIM_W'(i_cfg_data);
        clr_from = (cfg_sat < r_limit) ? cfg_sat : r_limit;
        clr      = cfg_hit;
    end

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        rrht_cell #(
            .MAX_ENTRIES (MAX_ENTRIES),
            .KEY_CODES   (KEY_CODES),
            .IDX         (g),
            .LIM_W       (LIM_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (chain_en),
            .i_tok      (tok[g]),
            .i_done     (done[g]),
            .i_cmd      (r_cmd),
            .i_limit    (r_limit),
            .i_clr      (clr),
            .i_clr_from (clr_from),
            .o_tok      (tok[g+1]),
            .o_done     (done[g+1]),
            .o_res_v    (cell_res_v[g]),
            .o_res      (cell_res[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_end      <= 1'b0;
            r_end_done <= 1'b0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_limit    <= LIM_W'(MAX_ENTRIES);
        end else begin
            if (cfg_hit) begin
                r_limit <= cfg_sat;
            end
            if (accept) begin
                r_cmd <= in_cmd;
            end
            if (start) begin
                r_busy <= 1'b1;
            end
            // load the output register, or drain it when the far side takes it
            if ((adv && res_any && r_pend_v) || finish) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && !i_out_stall) begin
                r_out_v <= 1'b0;
            end
            if (chain_en) begin
                r_end      <= tok[MAX_ENTRIES];
                r_end_done <= done[MAX_ENTRIES];
            end
            if (adv && res_any) begin
                r_pend   <= res_or;
                r_pend_v <= 1'b1;
                if (r_pend_v) begin
                    r_out <= r_pend;
                end
            end
            if (finish) begin
                r_pend_v <= 1'b0;
                r_end    <= 1'b0;
                r_busy   <= 1'b0;
                r_out    <= r_pend_v ? fin_res : end_res;
            end
        end
    end

    assign o_in_stall         = r_busy;
    assign o_out_valid        = r_out_v;
    assign o_status           = r_out.status;
    assign o_tile_id_res      = r_out.tile_id;
    assign o_pos_x_res        = r_out.pos_x;
    assign o_pos_y_res        = r_out.pos_y;
    assign o_width_res        = r_out.width;
    assign o_height_res       = r_out.height;
    assign o_tile_type_res    = r_out.tile_type;
    assign o_extra_value_res  = r_out.extra_value;
    assign o_private_flag_res = r_out.private_flag;
    assign o_owner_res        = r_out.owner;
    assign o_broadcast        = r_out.broadcast;
    assign o_last             = r_out.last;

    `RRHT_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok[MAX_ENTRIES:1]), "token duplicated")
    `RRHT_ASSERT_NOW(a_idle_empty, !r_busy, !r_pend_v && !r_end, "stale result while idle")
    `RRHT_ASSERT_NOW(a_done_pend, r_end && r_end_done, r_pend_v, "walk done but no result held")
    `RRHT_ASSERT_NEXT(a_finish, finish, !r_busy && r_out_v && r_out.last, "final result lost")

endmodule

### tb/rect_region_hit_table_checker.sv
// Checker for the click region table: shadow table, expected result queue, compare.
`timescale 1ns / 1ps
module rect_region_hit_table_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rrht_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  rrht_pkg::t_cmd              i_cmd,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  rrht_pkg::t_res              i_res,
    output int                          o_fail_count,
    output int                          o_pending
);
    import rrht_pkg::*;

    localparam int NT = MAX_ENTRIES_DEF;

    logic               live [NT];
    logic signed [15:0] cx [NT];
    logic signed [15:0] cy [NT];
    logic [14:0]        ew [NT];
    logic [14:0]        eh [NT];
    logic [1:0]         shape [NT];
    logic [31:0]        word [NT];
    logic               priv [NT];
    logic [7:0]         tag [NT];
    logic [255:0]       keys [NT];
    int                 limit;
    t_res               expected_results[$];

    assign o_pending = expected_results.size();

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    function automatic void wipe_tile(int i);
        live[i] = 0; cx[i] = 0; cy[i] = 0; ew[i] = 0; eh[i] = 0;
        shape[i] = 0; word[i] = 0; priv[i] = 0; tag[i] = 0; keys[i] = '0;
    endfunction

    function automatic t_res blank(logic [2:0] st, logic [5:0] id);
        t_res r;
        r = '0;
        r.status = st;
        r.tile_id = id;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic predict_request(input t_cmd c);
        t_res r;
        int i, n;
        int px, py;
        if (c.opcode > OP_DETECT) return;
        if (c.opcode == OP_CREATE) begin
            for (i = 0; i < limit; i++) if (!live[i]) break;
            if (i >= limit) begin
                expected_results.push_back(blank(ST_FULL, 0));
                return;
            end
            wipe_tile(i);
            cx[i] = c.pos_x; cy[i] = c.pos_y; ew[i] = c.width; eh[i] = c.height;
            shape[i] = c.tile_type; word[i] = c.extra_value;
            priv[i] = c.private_flag; tag[i] = c.owner;
            keys[i][c.key_code] = 1'b1;
            live[i] = 1'b1;
            expected_results.push_back(blank(ST_OK, i[5:0]));
            return;
        end
        if (c.opcode == OP_DETECT) begin
            n = 0;
            px = c.pos_x;
            py = c.pos_y;
            for (i = 0; i < limit; i++) begin
                if (!live[i] || !keys[i][c.key_code] || shape[i] != 0) continue;
                if (px < int'(cx[i]) || px > int'(cx[i]) + int'(ew[i])) continue;
                if (py < int'(cy[i]) || py > int'(cy[i]) + int'(eh[i])) continue;
                r = blank(ST_HIT, i[5:0]);
                r.pos_x = c.pos_x;
                r.pos_y = c.pos_y;
                r.owner = tag[i];
                r.broadcast = !(tag[i] != 0 && priv[i]);
                r.last = 1'b0;
                expected_results.push_back(r);
                n++;
            end
            if (n == 0) expected_results.push_back(blank(ST_NO_HIT, 0));
            else expected_results[$].last = 1'b1;
            return;
        end
        if (c.tile_id >= limit || !live[c.tile_id]) begin
            expected_results.push_back(blank(ST_INVALID, c.tile_id));
            return;
        end
        i = c.tile_id;
        r = blank(ST_OK, c.tile_id);
        case (c.opcode)
            OP_ADD_KEY: keys[i][c.key_code] = 1'b1;
            OP_DESTROY: wipe_tile(i);
            OP_SET_TYP: begin
                if (c.tile_type <= 1) shape[i] = c.tile_type;
                else r.status = ST_REJECT;
            end
            OP_SET_POS: begin cx[i] = c.pos_x; cy[i] = c.pos_y; end
            OP_SET_SZ:  begin ew[i] = c.width; eh[i] = c.height; end
            OP_SET_EXT: word[i] = c.extra_value;
            OP_SET_PRV: priv[i] = c.private_flag;
            OP_SET_OWN: tag[i] = c.owner;
            default: begin
                r.pos_x = cx[i]; r.pos_y = cy[i]; r.width = ew[i]; r.height = eh[i];
                r.tile_type = shape[i]; r.extra_value = word[i];
                r.private_flag = priv[i]; r.owner = tag[i];
            end
        endcase
        expected_results.push_back(r);
    endtask

    task automatic apply_limit(input logic [CFG_W-1:0] val);
        int v, lo;
        v = val;
        if (v == 0) return;
        if (v > NT) v = NT;
        lo = (v < limit) ? v : limit;
        for (int i = lo; i < NT; i++) wipe_tile(i);
        limit = v;
    endtask

    task automatic compare_result(input t_res got);
        t_res e;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result status %0d", got.status));
            return;
        end
        e = expected_results.pop_front();
        if (got.status != e.status)
            report_mismatch($sformatf("status %0d exp %0d", got.status, e.status));
        if (got.tile_id != e.tile_id)
            report_mismatch($sformatf("tile_id %0d exp %0d", got.tile_id, e.tile_id));
        if (got.pos_x != e.pos_x) report_mismatch($sformatf("pos_x %0d exp %0d", got.pos_x, e.pos_x));
        if (got.pos_y != e.pos_y) report_mismatch($sformatf("pos_y %0d exp %0d", got.pos_y, e.pos_y));
        if (got.width != e.width) report_mismatch($sformatf("width %0d exp %0d", got.width, e.width));
        if (got.height != e.height)
            report_mismatch($sformatf("height %0d exp %0d", got.height, e.height));
        if (got.tile_type != e.tile_type)
            report_mismatch($sformatf("type %0d exp %0d", got.tile_type, e.tile_type));
        if (got.extra_value != e.extra_value)
            report_mismatch($sformatf("extra %0h exp %0h", got.extra_value, e.extra_value));
        if (got.private_flag != e.private_flag) report_mismatch("private flag");
        if (got.owner != e.owner) report_mismatch($sformatf("owner %0d exp %0d", got.owner, e.owner));
        if (got.broadcast != e.broadcast) report_mismatch("broadcast");
        if (got.last != e.last) report_mismatch("last");
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NT; i++) wipe_tile(i);
            limit = NT;
            expected_results.delete();
        end else begin
            if (i_cfg_we) apply_limit(i_cfg_data);
            if (i_in_valid && !i_in_stall) predict_request(i_cmd);
            if (i_out_valid && !i_out_stall) compare_result(i_res);
        end
    end
endmodule

### tb/rect_region_hit_table_tb.sv
// Top of the click region table testbench: stimulus, backpressure and verdict.
`timescale 1ns / 1ps
module rect_region_hit_table_tb;
    import rrht_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES = 400;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    t_cmd             cmd;
    logic             out_valid;
    logic             out_stall;
    t_res             res;
    int               fail_count;
    int               pending;
    int               cycle_count;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               hold_off;
    logic             hold_start;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    rect_region_hit_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_opcode(cmd.opcode), .i_tile_id(cmd.tile_id),
        .i_pos_x(cmd.pos_x), .i_pos_y(cmd.pos_y),
        .i_width(cmd.width), .i_height(cmd.height),
        .i_tile_type(cmd.tile_type), .i_extra_value(cmd.extra_value),
        .i_private_flag(cmd.private_flag), .i_owner(cmd.owner),
        .i_key_code(cmd.key_code),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(res.status), .o_tile_id_res(res.tile_id),
        .o_pos_x_res(res.pos_x), .o_pos_y_res(res.pos_y),
        .o_width_res(res.width), .o_height_res(res.height),
        .o_tile_type_res(res.tile_type), .o_extra_value_res(res.extra_value),
        .o_private_flag_res(res.private_flag), .o_owner_res(res.owner),
        .o_broadcast(res.broadcast), .o_last(res.last)
    );

    rect_region_hit_table_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_cmd(cmd),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_res(res),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Watchdog: end the run if the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stall, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            hold_off <= 0;
        end else if (hold_start) begin
            out_stall <= 1'b1;
            hold_off <= HOLD_CYCLES;
        end else if (hold_off > 0) begin
            out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Offer one request and hold it until the block takes it; valid stays up after.
    task automatic send_request(input t_cmd c);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    // Drop valid, wait until all results are back, then let the walk settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] val);
        drain_results();
        cfg_we <= 1'b1;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic t_cmd random_request(input int max_id);
        t_cmd c;
        int sel;
        c.opcode = 4'($urandom_range(10));
        sel = $urandom_range(99);
        if (sel < 30) c.opcode = OP_DETECT;
        else if (sel < 42) c.opcode = OP_CREATE;
        else if (sel < 44) c.opcode = 4'($urandom_range(15, 11));
        c.tile_id = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(max_id));
        // Small coordinates so points land inside tiles often; sometimes full range.
        if ($urandom_range(3) == 0) begin
            c.pos_x = 16'($urandom); c.pos_y = 16'($urandom);
            c.width = 15'($urandom); c.height = 15'($urandom);
        end else begin
            c.pos_x = 16'($signed($urandom_range(80)) - 40);
            c.pos_y = 16'($signed($urandom_range(80)) - 40);
            c.width = 15'($urandom_range(40));
            c.height = 15'($urandom_range(40));
        end
        c.tile_type = ($urandom_range(3) == 0) ? 2'($urandom) : 2'd0;
        c.extra_value = $urandom;
        c.private_flag = 1'($urandom);
        c.owner = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom);
        c.key_code = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
        return c;
    endfunction

    function automatic t_cmd make_request(input logic [3:0] op, input int id,
                                          input int x, input int y, input int w,
                                          input int h, input int ty,
                                          input int own, input int key);
        t_cmd c;
        c = '0;
        c.opcode = op; c.tile_id = 6'(id);
        c.pos_x = 16'(x); c.pos_y = 16'(y); c.width = 15'(w); c.height = 15'(h);
        c.tile_type = 2'(ty); c.key_code = 8'(key);
        c.extra_value = 32'h8000_0001 ^ {24'd0, c.key_code};
        c.private_flag = own[0]; c.owner = 8'(own);
        return c;
    endfunction

    initial begin
        t_cmd c;
        int lim;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = '0;
        hold_start = 1'b0;
        send_idle_pct = 25;
        recv_idle_pct = 82;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every opcode, boundary hits, ellipse, bad type, full table.
        write_limit(7'd2);
        send_request(make_request(OP_CREATE, 0, -32768, -32768, 32767, 32767, 0, 255, 255));
        send_request(make_request(OP_CREATE, 0, 32767, 32767, 0, 0, 0, 0, 0));
        send_request(make_request(OP_CREATE, 0, 0, 0, 5, 5, 0, 3, 1));
        send_request(make_request(OP_DETECT, 0, -32768, -32768, 0, 0, 0, 0, 255));
        send_request(make_request(OP_DETECT, 0, -1, -1, 0, 0, 0, 0, 255));
        send_request(make_request(OP_DETECT, 0, 32767, 32767, 0, 0, 0, 0, 0));
        send_request(make_request(OP_DETECT, 0, 0, 0, 0, 0, 0, 0, 7));
        send_request(make_request(OP_ADD_KEY, 1, 0, 0, 0, 0, 0, 0, 255));
        send_request(make_request(OP_DETECT, 0, 32767, 32767, 0, 0, 0, 0, 255));
        send_request(make_request(OP_SET_TYP, 1, 0, 0, 0, 0, 3, 0, 0));
        send_request(make_request(OP_SET_TYP, 1, 0, 0, 0, 0, 1, 0, 0));
        send_request(make_request(OP_DETECT, 0, 32767, 32767, 0, 0, 0, 0, 255));
        send_request(make_request(OP_SET_POS, 0, 10, -10, 0, 0, 0, 0, 0));
        send_request(make_request(OP_SET_SZ, 0, 0, 0, 0, 32767, 0, 0, 0));
        send_request(make_request(OP_SET_EXT, 0, 0, 0, 0, 0, 0, 0, 255));
        send_request(make_request(OP_SET_PRV, 0, 0, 0, 0, 0, 0, 1, 0));
        send_request(make_request(OP_SET_OWN, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_READ, 2, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_READ, 63, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_DESTROY, 1, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_READ, 1, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(4'd15, 0, 0, 0, 0, 0, 0, 0, 0));
        write_limit(7'd0);
        write_limit(7'd127);
        send_request(make_request(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));

        // Random phases under different idle mixes and limits.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin lim = 64; send_idle_pct = 25; recv_idle_pct = 82; end
                1: begin lim = 1;  send_idle_pct = 82; recv_idle_pct = 25; end
                2: begin lim = 12; send_idle_pct = 0;  recv_idle_pct = 0;  end
                default: begin lim = 64; send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            write_limit(7'(lim));
            // Hold the receiver off for a long stretch so the block fills and stalls.
            if (ph == 2) begin
                hold_start <= 1'b1;
                @(posedge i_clk);
                hold_start <= 1'b0;
            end
            for (int n = 0; n < 59; n++) begin
                c = random_request((lim < 64) ? lim + 1 : 63);
                send_request(c);
            end
        end

        drain_results();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
